// ----- sv/dcts_pkg.sv -----
package dcts_pkg;

	localparam int HASH_W = 64;
	localparam int INST_W = 32;
	localparam int COND_W = 6;
	localparam int MAP_W  = 32;
	localparam int EXEC_W = 64;
	localparam int OP_W   = 2;

	// event kinds; the fourth code is ignored
	typedef enum logic [OP_W-1:0] {
		OP_BEGIN    = 2'd0,
		OP_COND     = 2'd1,
		OP_COMPLETE = 2'd2
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic capture;
		logic apply;
	} cmd_t;

	typedef struct packed {
		logic stall;
	} status_t;

endpackage

// ----- sv/dcts_ifs.sv -----
interface dcts_in_if;
	logic                       valid;
	logic                       ready;
	logic [dcts_pkg::OP_W-1:0]   opcode;
	logic [dcts_pkg::HASH_W-1:0] decision_hash;
	logic [dcts_pkg::INST_W-1:0] instance_index;
	logic [dcts_pkg::COND_W-1:0] cond_number;
	logic                       bit_value;

	modport source (
		output valid, opcode, decision_hash, instance_index, cond_number, bit_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, decision_hash, instance_index, cond_number, bit_value,
		output ready
	);
endinterface

interface dcts_out_if;
	logic                       valid;
	logic                       ready;
	logic [dcts_pkg::HASH_W-1:0] logical_id;
	logic [dcts_pkg::HASH_W-1:0] physical_id;
	logic [dcts_pkg::EXEC_W-1:0] execution_number;
	logic [dcts_pkg::MAP_W-1:0]  evaluated_bits;
	logic [dcts_pkg::MAP_W-1:0]  value_bits;
	logic                       outcome;

	modport source (
		output valid, logical_id, physical_id, execution_number, evaluated_bits,
		       value_bits, outcome,
		input  ready
	);
	modport sink (
		input  valid, logical_id, physical_id, execution_number, evaluated_bits,
		       value_bits, outcome,
		output ready
	);
endinterface

// ----- sv/dcts_ctrl.sv -----
module dcts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dcts_pkg::status_t status,
	output dcts_pkg::cmd_t    cmd
);

	dcts_pkg::state_t state_q;
	dcts_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dcts_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = dcts_pkg::ST_UPDATE;
				end
			end
			dcts_pkg::ST_UPDATE: begin
				if (!status.stall) begin
					state_d = dcts_pkg::ST_IDLE;
				end
			end
			default: state_d = dcts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.apply   = 1'b0;
		case (state_q)
			dcts_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			dcts_pkg::ST_UPDATE: begin
				// hold while a new record cannot enter the output register
				cmd.apply = !status.stall;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- sv/dcts_datapath.sv -----
module dcts_datapath #(
	parameter int STACK_DEPTH = 16,
	parameter int MAX_CONDS   = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dcts_pkg::cmd_t              cmd,
	output dcts_pkg::status_t           status,
	input  logic [dcts_pkg::OP_W-1:0]   opcode,
	input  logic [dcts_pkg::HASH_W-1:0] decision_hash,
	input  logic [dcts_pkg::INST_W-1:0] instance_index,
	input  logic [dcts_pkg::COND_W-1:0] cond_number,
	input  logic                        bit_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dcts_pkg::HASH_W-1:0] logical_id,
	output logic [dcts_pkg::HASH_W-1:0] physical_id,
	output logic [dcts_pkg::EXEC_W-1:0] execution_number,
	output logic [dcts_pkg::MAP_W-1:0]  evaluated_bits,
	output logic [dcts_pkg::MAP_W-1:0]  value_bits,
	output logic                        outcome
);

	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int HW    = dcts_pkg::HASH_W;
	localparam int IW    = dcts_pkg::INST_W;
	localparam int CW    = dcts_pkg::COND_W;

	// stack storage
	logic [HW-1:0]          ent_hash_q [STACK_DEPTH];
	logic [IW-1:0]          ent_inst_q [STACK_DEPTH];
	logic [MAX_CONDS-1:0]   ent_eval_q [STACK_DEPTH];
	logic [MAX_CONDS-1:0]   ent_vals_q [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] active_q;
	logic [LVL_W-1:0]       level_q;
	logic [dcts_pkg::EXEC_W-1:0] exec_q;

	// captured item and match results
	logic [dcts_pkg::OP_W-1:0] op_q;
	logic [HW-1:0]          ev_hash_q;
	logic [IW-1:0]          ev_inst_q;
	logic [CW-1:0]          ev_cond_q;
	logic                   ev_val_q;
	logic [STACK_DEPTH-1:0] hit_q;
	logic                   top_ok_q;

	logic [STACK_DEPTH-1:0] hit_d;
	logic [STACK_DEPTH-1:0] is_top;
	logic                   top_ok_d;
	logic                   found;
	logic [IDX_W-1:0]       hit_idx;
	logic                   hit_is_top;
	logic                   emit;
	logic                   cond_ok;
	logic                   full;
	logic [dcts_pkg::MAP_W-1:0] rd_eval;
	logic [dcts_pkg::MAP_W-1:0] rd_vals;
	logic                   out_valid_q;

	// compare every entry against the incoming item
	always_comb begin
		top_ok_d = 1'b0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			is_top[i] = (LVL_W'(i + 1) == level_q);
			hit_d[i]  = active_q[i] && (ent_hash_q[i] == decision_hash) &&
			            (ent_inst_q[i] == instance_index);
			if (is_top[i] && active_q[i] && (ent_hash_q[i] == decision_hash)) begin
				top_ok_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			ev_hash_q <= decision_hash;
			ev_inst_q <= instance_index;
			ev_cond_q <= cond_number;
			ev_val_q  <= bit_value;
			hit_q     <= hit_d;
			top_ok_q  <= top_ok_d;
		end
	end

	// highest matching entry wins
	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if (hit_q[i]) begin
				found   = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign hit_is_top = (LVL_W'(hit_idx) + LVL_W'(1)) == level_q;
	assign emit       = (op_q == dcts_pkg::OP_COMPLETE) && found;
	assign cond_ok    = ev_cond_q < CW'(MAX_CONDS);
	assign full       = level_q == LVL_W'(STACK_DEPTH);
	assign status.stall = emit && out_valid_q && !out_ready;

	always_comb begin
		rd_eval = '0;
		rd_vals = '0;
		rd_eval[MAX_CONDS-1:0] = ent_eval_q[hit_idx];
		rd_vals[MAX_CONDS-1:0] = ent_vals_q[hit_idx];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			if (cmd.apply) begin
				case (op_q)
					dcts_pkg::OP_BEGIN: begin
						if (!full && (LVL_W'(i) == level_q)) begin
							ent_hash_q[i] <= ev_hash_q;
							ent_inst_q[i] <= ev_inst_q;
							ent_eval_q[i] <= '0;
							ent_vals_q[i] <= '0;
						end
					end
					dcts_pkg::OP_COND: begin
						if (top_ok_q && cond_ok && is_top[i]) begin
							for (int j = 0; j < MAX_CONDS; j++) begin
								if (ev_cond_q == CW'(j)) begin
									ent_eval_q[i][j] <= 1'b1;
									ent_vals_q[i][j] <= ev_val_q;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			level_q  <= '0;
			exec_q   <= dcts_pkg::EXEC_W'(1);
		end else if (cmd.apply) begin
			case (op_q)
				dcts_pkg::OP_BEGIN: begin
					if (!full) begin
						for (int i = 0; i < STACK_DEPTH; i++) begin
							if (LVL_W'(i) == level_q) begin
								active_q[i] <= 1'b1;
							end
						end
						level_q <= level_q + LVL_W'(1);
					end
				end
				dcts_pkg::OP_COMPLETE: begin
					if (found) begin
						active_q[hit_idx] <= 1'b0;
						exec_q <= exec_q + dcts_pkg::EXEC_W'(1);
						if (hit_is_top) begin
							level_q <= level_q - LVL_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply && emit) begin
			logical_id       <= ev_hash_q;
			physical_id      <= {ev_inst_q, {(HW - IW){1'b0}}} ^ ev_hash_q;
			execution_number <= exec_q;
			evaluated_bits   <= rd_eval;
			value_bits       <= rd_vals;
			outcome          <= ev_val_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/decision_coverage_trace_stack.sv -----
// A record enters the output register when the update state applies a matching complete item.
// Items are taken one at a time: idle registers a parallel compare of the item against every
//   stack entry, and the update state resolves the top-most match and updates the stack.
// The update cycle waits only while a record is due and the output register is still full.
// Reset (arst_n, asynchronous, active low) empties the stack, clears all active marks,
//   sets the execution count to one and drops the output valid; entry data is not cleared.
module decision_coverage_trace_stack #(
	parameter int STACK_DEPTH = 16,
	parameter int MAX_CONDS   = 32
) (
	input logic       clk,
	input logic       arst_n,
	dcts_in_if.sink   in_ch,
	dcts_out_if.source out_ch
);

	dcts_pkg::cmd_t    cmd;
	dcts_pkg::status_t status;

	// Controller: two states. Idle takes an item (ready is high) and fires the capture
	// command, which latches the payload and the per-entry match vector. Update fires
	// the apply command once no stall is signalled; it pushes, marks a condition, or retires a context.
	dcts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: the entry registers, the compare and priority logic, the execution
	// counter and the output register. A record waiting in the output register does not
	// block the next item; only a second record due before the first is taken stalls.
	dcts_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_CONDS   (MAX_CONDS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.opcode           (in_ch.opcode),
		.decision_hash    (in_ch.decision_hash),
		.instance_index   (in_ch.instance_index),
		.cond_number      (in_ch.cond_number),
		.bit_value        (in_ch.bit_value),
		.out_valid        (out_ch.valid),
		.out_ready        (out_ch.ready),
		.logical_id       (out_ch.logical_id),
		.physical_id      (out_ch.physical_id),
		.execution_number (out_ch.execution_number),
		.evaluated_bits   (out_ch.evaluated_bits),
		.value_bits       (out_ch.value_bits),
		.outcome          (out_ch.outcome)
	);

endmodule

// ----- sv/dcts_checker.sv -----
module dcts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] logical_id,
	input logic [63:0] physical_id,
	input logic [63:0] execution_number
);

	// a stalled record holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(execution_number) &&
		$stable(logical_id))
		else $error("output record changed while stalled");

	// the block works on one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken during the update cycle");

	// a fresh record follows an accepted item
	a_rec_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("record appeared without a completing item");

	// physical id differs from the hash only in its upper half
	a_phys_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> physical_id[31:0] == logical_id[31:0])
		else $error("physical id low half does not match hash");

endmodule

bind decision_coverage_trace_stack dcts_checker u_dcts_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_ch.valid),
	.in_ready         (in_ch.ready),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.logical_id       (out_ch.logical_id),
	.physical_id      (out_ch.physical_id),
	.execution_number (out_ch.execution_number)
);
